// ===== design/hpid_pkg.sv =====
package hpid_pkg;

    // datapath field widths
    localparam int TempW   = 14;
    localparam int AdcW    = 12;
    localparam int OffW    = 12;
    localparam int GainW   = 16;
    localparam int SmoothW = 9;
    localparam int IntegW  = 13;
    localparam int ErrW    = 16;
    localparam int DeltaW  = 15;
    localparam int FiltW   = 24;
    localparam int DutyW   = 8;
    localparam int CodeW   = 4;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;

    // register indexes of the config port
    localparam logic [CfgIdxW-1:0] REG_TARGET   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_OFFSET   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PGAIN    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_IGAIN    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DGAIN    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SMOOTH   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_RANGE    = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_MAXTEMP  = 3'd7;

    // reset values
    localparam logic [SmoothW-1:0] SMOOTH_RST  = 9'd243;
    localparam logic [TempW-1:0]   RANGE_RST   = 14'd160;
    localparam logic [TempW-1:0]   MAXTEMP_RST = 14'd4800;

    // fault limits
    localparam logic [AdcW-1:0]  NTC_HOT_LIMIT = 12'd583;
    localparam logic [TempW-1:0] SHORT_LIMIT   = 14'd14400;
    localparam logic [TempW-1:0] OVER_MARGIN   = 14'd160;

    // fault code bits
    localparam logic [CodeW-1:0] CODE_OPEN  = 4'b0001;
    localparam logic [CodeW-1:0] CODE_SHORT = 4'b0010;
    localparam logic [CodeW-1:0] CODE_OVER  = 4'b0100;
    localparam logic [CodeW-1:0] CODE_BOARD = 4'b1000;

    localparam logic [IntegW-1:0] INTEG_MAX = 13'd4096;
    localparam logic [DutyW-1:0]  DUTY_MAX  = 8'd255;
    localparam int                SUM_MAX   = 255 * 256;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_EVAL,
        CMD_MUL_GAIN,
        CMD_MUL_DT,
        CMD_MUL_FILT,
        CMD_MUL_PROP,
        CMD_MUL_INTEG,
        CMD_FINISH
    } hpid_cmd_t;

    typedef struct packed {
        logic pid_run;
        logic out_busy;
    } hpid_status_t;

endpackage

// ===== design/hpid_ctrl.sv =====
module hpid_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  hpid_pkg::hpid_status_t status,
    output logic                  in_stall,
    output hpid_pkg::hpid_cmd_t   cmd
);
    import hpid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_GAIN,
        S_DT,
        S_FILT,
        S_PROP,
        S_INTEG,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd        = CMD_EVAL;
                    state_next = status.pid_run ? S_GAIN : S_IDLE;
                end
            end
            S_GAIN:
            begin
                cmd        = CMD_MUL_GAIN;
                state_next = S_DT;
            end
            S_DT:
            begin
                cmd        = CMD_MUL_DT;
                state_next = S_FILT;
            end
            S_FILT:
            begin
                cmd        = CMD_MUL_FILT;
                state_next = S_PROP;
            end
            S_PROP:
            begin
                cmd        = CMD_MUL_PROP;
                state_next = S_INTEG;
            end
            S_INTEG:
            begin
                cmd        = CMD_MUL_INTEG;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd        = CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/hpid_dpath.sv =====
module hpid_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hpid_pkg::hpid_cmd_t                   cmd,
    output hpid_pkg::hpid_status_t                status,
    input  logic [hpid_pkg::TempW-1:0]            heater_temp,
    input  logic [hpid_pkg::AdcW-1:0]             board_ntc_adc,
    input  logic                                  external_fault,
    input  logic                                  cfg_write,
    input  logic [hpid_pkg::CfgIdxW-1:0]          cfg_index,
    input  logic [hpid_pkg::CfgDatW-1:0]          cfg_data,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic [hpid_pkg::DutyW-1:0]            heater_pwm,
    output logic                                  fault_flag,
    output logic [hpid_pkg::CodeW-1:0]            error_mask
);
    import hpid_pkg::*;

    localparam int MulAW = 26;
    localparam int MulBW = 17;
    localparam int ProdW = MulAW + MulBW;
    localparam int DaccW = 28;
    localparam int DsumW = 29;
    localparam int AccW  = 32;

    // config registers
    logic [TempW-1:0]         target_reg;
    logic signed [OffW-1:0]   offset_reg;
    logic [GainW-1:0]         pgain_reg;
    logic [GainW-1:0]         igain_reg;
    logic [GainW-1:0]         dgain_reg;
    logic [SmoothW-1:0]       smooth_reg;
    logic [TempW-1:0]         range_reg;
    logic [TempW-1:0]         maxtemp_reg;

    // controller state
    logic [IntegW-1:0]        integ_reg;
    logic [TempW-1:0]         prev_reg;
    logic signed [FiltW-1:0]  filt_reg;
    logic                     pending_reg;
    logic [CodeW-1:0]         codes_reg;
    logic                     out_valid_reg;

    // working registers
    logic [TempW-1:0]         temp_reg;
    logic [AdcW-1:0]          adc_reg;
    logic                     ext_reg;
    logic signed [ErrW-1:0]   err_reg;
    logic signed [DeltaW-1:0] delta_reg;
    logic signed [ProdW-1:0]  prod_reg;
    logic signed [DaccW-1:0]  dacc_reg;
    logic signed [AccW-1:0]   acc_reg;
    logic [DutyW-1:0]         pwm_reg;
    logic                     herr_reg;
    logic [CodeW-1:0]         mask_reg;

    // combinational terms
    logic [CodeW-1:0]         fault_code;
    logic                     fault;
    logic [CodeW-1:0]         codes_next;
    logic signed [ErrW-1:0]   err_c;
    logic signed [ErrW-1:0]   band_c;
    logic                     above_band;
    logic                     below_band;
    logic                     pid_run;
    logic                     out_load;
    logic [SmoothW-1:0]       k1;
    logic [SmoothW-1:0]       k2;
    logic [IntegW-1:0]        integ_start;
    logic [IntegW-1:0]        integ_acc;
    logic [IntegW-1:0]        integ_back;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [ProdW-1:0]  mul_p;
    logic signed [ProdW-1:0]  prod_q12;
    logic signed [ProdW-1:0]  prod_q8;
    logic signed [ProdW-1:0]  prod_q4;
    logic signed [DsumW-1:0]  dsum;
    logic signed [FiltW-1:0]  dsat;
    logic signed [AccW-1:0]   sum_c;
    logic [TempW:0]           over_limit;

    function automatic logic [IntegW-1:0] clamp_integ(input logic signed [IntegW+3:0] v);
        logic [IntegW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({4'b0000, INTEG_MAX}))
            r = INTEG_MAX;
        else
            r = v[IntegW-1:0];
        return r;
    endfunction

    // fault priority: open, short, over-temp, board hot, external
    assign over_limit = {1'b0, maxtemp_reg} + {1'b0, OVER_MARGIN};

    always_comb
    begin
        fault_code = '0;
        fault      = 1'b1;
        if (temp_reg == '0)
            fault_code = CODE_OPEN;
        else if (temp_reg > SHORT_LIMIT)
            fault_code = CODE_SHORT;
        else if ({1'b0, temp_reg} > over_limit)
            fault_code = CODE_OVER;
        else if (adc_reg > NTC_HOT_LIMIT)
            fault_code = CODE_BOARD;
        else
            fault = ext_reg;
    end

    assign codes_next = fault ? (codes_reg | fault_code) : '0;

    assign err_c = $signed({2'b00, target_reg}) + $signed({{4{offset_reg[OffW-1]}}, offset_reg})
                 - $signed({2'b00, temp_reg});
    assign band_c     = $signed({2'b00, range_reg});
    assign above_band = err_c > band_c;
    assign below_band = err_c < -band_c;
    assign pid_run    = !fault && (target_reg != '0) && !above_band && !below_band;

    assign status.pid_run  = pid_run;
    assign status.out_busy = out_valid_reg && out_stall;

    // a new result word enters the output register
    assign out_load = ((cmd == CMD_EVAL) && !pid_run) || (cmd == CMD_FINISH);

    assign k1 = (smooth_reg > 9'd256) ? 9'd256 : smooth_reg;
    assign k2 = 9'd256 - k1;

    assign integ_start = pending_reg ? '0 : integ_reg;
    assign integ_acc   = clamp_integ($signed({4'b0000, integ_start}) + 17'(err_c));
    assign integ_back  = clamp_integ($signed({4'b0000, integ_reg}) - 17'(err_reg));

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            CMD_MUL_GAIN:
            begin
                mul_a = $signed({10'b0, dgain_reg});
                mul_b = $signed({8'b0, k2});
            end
            CMD_MUL_DT:
            begin
                mul_a = $signed({1'b0, prod_reg[24:0]});
                mul_b = $signed({{2{delta_reg[DeltaW-1]}}, delta_reg});
            end
            CMD_MUL_FILT:
            begin
                mul_a = $signed({{2{filt_reg[FiltW-1]}}, filt_reg});
                mul_b = $signed({8'b0, k1});
            end
            CMD_MUL_PROP:
            begin
                mul_a = $signed({10'b0, pgain_reg});
                mul_b = $signed({err_reg[ErrW-1], err_reg});
            end
            CMD_MUL_INTEG:
            begin
                mul_a = $signed({10'b0, igain_reg});
                mul_b = $signed({4'b0, integ_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divisions by powers of two, rounding toward zero
    assign prod_q12 = (prod_reg + (prod_reg[ProdW-1] ? 43'sd4095 : 43'sd0)) >>> 12;
    assign prod_q8  = (prod_reg + (prod_reg[ProdW-1] ? 43'sd255 : 43'sd0)) >>> 8;
    assign prod_q4  = (prod_reg + (prod_reg[ProdW-1] ? 43'sd15 : 43'sd0)) >>> 4;

    assign dsum = 29'(dacc_reg) + $signed(prod_q8[DsumW-1:0]);

    always_comb
    begin
        if (dsum > 29'sd8388607)
            dsat = 24'sh7FFFFF;
        else if (dsum < -29'sd8388608)
            dsat = 24'sh800000;
        else
            dsat = dsum[FiltW-1:0];
    end

    assign sum_c = acc_reg + prod_q4[AccW-1:0];

    // config, pid state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            offset_reg    <= '0;
            pgain_reg     <= '0;
            igain_reg     <= '0;
            dgain_reg     <= '0;
            smooth_reg    <= SMOOTH_RST;
            range_reg     <= RANGE_RST;
            maxtemp_reg   <= MAXTEMP_RST;
            integ_reg     <= '0;
            prev_reg      <= '0;
            filt_reg      <= '0;
            pending_reg   <= 1'b1;
            codes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TARGET:
                    begin
                        target_reg  <= cfg_data[TempW-1:0];
                        pending_reg <= 1'b1;
                        filt_reg    <= '0;
                    end
                    REG_OFFSET:  offset_reg  <= cfg_data[OffW-1:0];
                    REG_PGAIN:   pgain_reg   <= cfg_data;
                    REG_IGAIN:   igain_reg   <= cfg_data;
                    REG_DGAIN:   dgain_reg   <= cfg_data;
                    REG_SMOOTH:  smooth_reg  <= cfg_data[SmoothW-1:0];
                    REG_RANGE:   range_reg   <= cfg_data[TempW-1:0];
                    REG_MAXTEMP: maxtemp_reg <= cfg_data[TempW-1:0];
                    default:     ;
                endcase
            end

            case (cmd)
                CMD_EVAL:
                begin
                    codes_reg <= codes_next;
                    if (!fault && target_reg != '0)
                    begin
                        prev_reg <= temp_reg;
                        if (above_band || below_band)
                        begin
                            pending_reg <= 1'b1;
                        end
                        else
                        begin
                            pending_reg <= 1'b0;
                            integ_reg   <= integ_acc;
                        end
                    end
                end
                CMD_MUL_PROP:
                begin
                    filt_reg <= dsat;
                end
                CMD_FINISH:
                begin
                    // conditional un-integration when the output saturates
                    if (sum_c > 32'(SUM_MAX))
                    begin
                        if (err_reg > 0)
                            integ_reg <= integ_back;
                    end
                    else if (sum_c <= 0)
                    begin
                        if (err_reg <= 0)
                            integ_reg <= integ_back;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers and output word
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                temp_reg <= heater_temp;
                adc_reg  <= board_ntc_adc;
                ext_reg  <= external_fault;
            end
            CMD_EVAL:
            begin
                err_reg   <= err_c;
                delta_reg <= $signed({1'b0, temp_reg}) - $signed({1'b0, prev_reg});
                if (!pid_run)
                begin
                    pwm_reg  <= (!fault && target_reg != '0 && above_band) ? DUTY_MAX : '0;
                    herr_reg <= fault;
                    mask_reg <= codes_next;
                end
            end
            CMD_MUL_GAIN, CMD_MUL_DT, CMD_MUL_PROP:
            begin
                prod_reg <= mul_p;
            end
            CMD_MUL_FILT:
            begin
                dacc_reg <= prod_q12[DaccW-1:0];
                prod_reg <= mul_p;
            end
            CMD_MUL_INTEG:
            begin
                // proportional term less the freshly filtered derivative
                acc_reg  <= prod_q4[AccW-1:0] - 32'(filt_reg);
                prod_reg <= mul_p;
            end
            CMD_FINISH:
            begin
                if (sum_c > 32'(SUM_MAX))
                    pwm_reg <= DUTY_MAX;
                else if (sum_c <= 0)
                    pwm_reg <= '0;
                else
                    pwm_reg <= sum_c[15:8];
                herr_reg <= 1'b0;
                mask_reg <= codes_reg;
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign heater_pwm = pwm_reg;
    assign fault_flag = herr_reg;
    assign error_mask = mask_reg;

endmodule

// ===== design/heater_pid_with_fault_check.sv =====
// sequence: an accepted word is loaded and checked; for a fault, zero target or
// bang-bang period the check writes the result, else the pid makes five passes of
// one shared multiplier and a finish step writes it; in_stall is high until it is written
// reset: rst_n async active low; registers take their documented reset values,
// integrator reset pending set, pid state and latched codes cleared
module heater_pid_with_fault_check (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input words
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [hpid_pkg::TempW-1:0]            heater_temp,
    input  logic [hpid_pkg::AdcW-1:0]             board_ntc_adc,
    input  logic                                  external_fault,
    // result words
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [hpid_pkg::DutyW-1:0]            heater_pwm,
    output logic                                  fault_flag,
    output logic [hpid_pkg::CodeW-1:0]            error_mask,
    // config writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hpid_pkg::CfgIdxW-1:0]          cfg_index,
    input  logic [hpid_pkg::CfgDatW-1:0]          cfg_data
);
    import hpid_pkg::*;

    hpid_cmd_t    cmd;
    hpid_status_t status;

    // config registers take a write on any cycle
    assign cfg_ready = 1'b1;

    // sequencer: accept, fault/band check, five multiplies, finish
    hpid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // config, pid state, shared multiplier and the output register
    hpid_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .heater_temp    (heater_temp),
        .board_ntc_adc  (board_ntc_adc),
        .external_fault (external_fault),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .heater_pwm     (heater_pwm),
        .fault_flag     (fault_flag),
        .error_mask     (error_mask)
    );

endmodule
